// ===== sv/tcc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch click classifier package
// Shared types, event codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package tcc_pkg;

    localparam int CFG_WIDTH   = 16;
    localparam int LEVEL_WIDTH = 16;
    localparam int EVENT_WIDTH = 3;
    localparam int INDEX_WIDTH = 3;

    typedef logic [CFG_WIDTH-1:0]   cfg_word_t;
    typedef logic [EVENT_WIDTH-1:0] event_t;
    typedef logic [INDEX_WIDTH-1:0] reg_index_t;

    // Event encoding used on event_code and held_state.
    localparam event_t EV_NONE      = 3'd0;
    localparam event_t EV_CLICK     = 3'd1;
    localparam event_t EV_LONG      = 3'd2;
    localparam event_t EV_SUPERLONG = 3'd3;
    localparam event_t EV_DOUBLE    = 3'd4;

    // Configuration register indexes.
    localparam reg_index_t REG_TOUCH_THRESHOLD = 3'd0;
    localparam reg_index_t REG_CLICK_MIN       = 3'd1;
    localparam reg_index_t REG_LONG_PRESS      = 3'd2;
    localparam reg_index_t REG_SUPERLONG_EXTRA = 3'd3;
    localparam reg_index_t REG_DOUBLE_WINDOW   = 3'd4;

    // Configuration reset values.
    localparam cfg_word_t RST_TOUCH_THRESHOLD = 16'd30;
    localparam cfg_word_t RST_CLICK_MIN       = 16'd50;
    localparam cfg_word_t RST_LONG_PRESS      = 16'd1000;
    localparam cfg_word_t RST_SUPERLONG_EXTRA = 16'd3000;
    localparam cfg_word_t RST_DOUBLE_WINDOW   = 16'd260;

    typedef struct packed {
        cfg_word_t touch_threshold;
        cfg_word_t click_min_ms;
        cfg_word_t long_press_ms;
        cfg_word_t superlong_extra_ms;
        cfg_word_t double_window_ms;
    } cfg_t;

    typedef struct packed {
        event_t event_code;
        event_t held_state;
        logic   go_home_pulse;
        logic   stop_continue_pulse;
    } result_t;

endpackage

// ===== sv/touch_click_classifier.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch click classifier
// Classifies touch pad samples into click, long, super-long and double click
// events with valid/ready channels and a plain register write port.
// ----------------------------------------------------------------------------
// Path: a sample is held in the input register, and its result moves into the
// result register once that register is free or its result is taken.
// Throughput: one sample per cycle while results are taken; the classify logic
// sits between the input and result registers and updates its state in one pass.
// Reset: aresetn is synchronous and active low; it empties both registers,
// clears the press and click history and loads the register defaults.
module touch_click_classifier #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [tcc_pkg::INDEX_WIDTH-1:0] cfg_index,
    input  logic [tcc_pkg::CFG_WIDTH-1:0]   cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [tcc_pkg::LEVEL_WIDTH-1:0] s_touch_level,
    input  logic [31:0]                     s_now_ms,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [tcc_pkg::EVENT_WIDTH-1:0] m_event_code,
    output logic [tcc_pkg::EVENT_WIDTH-1:0] m_held_state,
    output logic                            m_go_home_pulse,
    output logic                            m_stop_continue_pulse
);
    import tcc_pkg::*;

    typedef logic [TIME_WIDTH-1:0] time_t;

    cfg_t    cfg_reg;
    logic    in_valid_reg;
    logic [LEVEL_WIDTH-1:0] level_reg;
    time_t   now_reg;
    logic    out_valid_reg;
    result_t out_reg;
    result_t result_next;
    logic    advance;

    // The sample moves into the result register when that register is free
    // or its result is being transferred out.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.touch_threshold    <= RST_TOUCH_THRESHOLD;
            cfg_reg.click_min_ms       <= RST_CLICK_MIN;
            cfg_reg.long_press_ms      <= RST_LONG_PRESS;
            cfg_reg.superlong_extra_ms <= RST_SUPERLONG_EXTRA;
            cfg_reg.double_window_ms   <= RST_DOUBLE_WINDOW;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_TOUCH_THRESHOLD: cfg_reg.touch_threshold    <= cfg_wdata;
                REG_CLICK_MIN:       cfg_reg.click_min_ms       <= cfg_wdata;
                REG_LONG_PRESS:      cfg_reg.long_press_ms      <= cfg_wdata;
                REG_SUPERLONG_EXTRA: cfg_reg.superlong_extra_ms <= cfg_wdata;
                REG_DOUBLE_WINDOW:   cfg_reg.double_window_ms   <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            level_reg <= s_touch_level;
            now_reg   <= time_t'(s_now_ms);
        end
        if (advance) begin
            out_reg <= result_next;
        end
    end

    tcc_core #(
        .TIME_WIDTH(TIME_WIDTH)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fire        (advance),
        .touch_level (level_reg),
        .now_time    (now_reg),
        .cfg         (cfg_reg),
        .result      (result_next)
    );

    assign m_valid               = out_valid_reg;
    assign m_event_code          = out_reg.event_code;
    assign m_held_state          = out_reg.held_state;
    assign m_go_home_pulse       = out_reg.go_home_pulse;
    assign m_stop_continue_pulse = out_reg.stop_continue_pulse;

endmodule

// ===== sv/tcc_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch click classifier core
// Holds the press timing and click history state and classifies one
// registered sample per cycle into a result, on the cycles when fire is high.
// ----------------------------------------------------------------------------
module tcc_core #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         fire,
    input  logic [tcc_pkg::LEVEL_WIDTH-1:0] touch_level,
    input  logic [TIME_WIDTH-1:0]        now_time,
    input  tcc_pkg::cfg_t                cfg,
    output tcc_pkg::result_t             result
);
    import tcc_pkg::*;

    typedef logic [TIME_WIDTH-1:0] time_t;

    logic   press_captured_reg, press_captured_next;
    time_t  mark_time_reg, mark_time_next;
    logic   long_reported_reg, long_reported_next;
    logic   superlong_reported_reg, superlong_reported_next;
    logic   click_parity_reg, click_parity_next;
    time_t  click_time_a_reg, click_time_a_next;
    time_t  click_time_b_reg, click_time_b_next;
    time_t  last_gap_reg, last_gap_next;
    event_t last_event_reg, last_event_next;

    logic   touched;
    time_t  mark_base;
    time_t  elapsed;
    logic   long_hit;
    logic   superlong_hit;
    logic   click_hit;
    logic   double_hit;
    time_t  gap_ab;
    time_t  gap_ba;
    event_t event_code;

    always_comb begin
        touched = touch_level < cfg.touch_threshold;

        // A touch without a captured press starts timing at this sample.
        mark_base = press_captured_reg ? mark_time_reg : now_time;
        elapsed   = now_time - (touched ? mark_base : mark_time_reg);

        long_hit = touched && !long_reported_reg
                   && (elapsed > time_t'(cfg.long_press_ms));
        // A long click moves the mark to now; super-long is held off by long_hit
        // in the same sample.
        superlong_hit = touched && !long_hit && !superlong_reported_reg
                        && (elapsed > time_t'(cfg.superlong_extra_ms));
        click_hit = !touched && !long_reported_reg
                    && (elapsed > time_t'(cfg.click_min_ms));

        click_time_a_next = (click_hit && click_parity_reg) ? now_time : click_time_a_reg;
        click_time_b_next = (click_hit && !click_parity_reg) ? now_time : click_time_b_reg;
        click_parity_next = click_parity_reg ^ click_hit;

        gap_ab = click_time_a_next - click_time_b_next;
        gap_ba = click_time_b_next - click_time_a_next;

        // Equal click times leave the previous gap in place.
        last_gap_next = last_gap_reg;
        if (click_hit) begin
            if (click_time_a_next > click_time_b_next) begin
                last_gap_next = gap_ab;
            end else if (click_time_a_next < click_time_b_next) begin
                last_gap_next = gap_ba;
            end else begin
                last_gap_next = last_gap_reg;
            end
        end
        double_hit = click_hit && (last_gap_next < time_t'(cfg.double_window_ms));

        priority if (superlong_hit) begin
            event_code = EV_SUPERLONG;
        end else if (long_hit) begin
            event_code = EV_LONG;
        end else if (double_hit) begin
            event_code = EV_DOUBLE;
        end else if (click_hit) begin
            event_code = EV_CLICK;
        end else begin
            event_code = EV_NONE;
        end

        if (touched) begin
            press_captured_next     = 1'b1;
            mark_time_next          = (long_hit || superlong_hit) ? now_time : mark_base;
            long_reported_next      = long_reported_reg || long_hit;
            superlong_reported_next = superlong_reported_reg || superlong_hit;
        end else begin
            press_captured_next     = press_captured_reg && !click_hit;
            mark_time_next          = now_time;
            long_reported_next      = 1'b0;
            superlong_reported_next = 1'b0;
        end

        last_event_next = (event_code != EV_NONE) ? event_code : last_event_reg;

        result.event_code          = event_code;
        result.held_state          = last_event_next;
        result.go_home_pulse       = long_hit;
        result.stop_continue_pulse = click_hit;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            press_captured_reg     <= 1'b0;
            mark_time_reg          <= '0;
            long_reported_reg      <= 1'b0;
            superlong_reported_reg <= 1'b0;
            click_parity_reg       <= 1'b0;
            click_time_a_reg       <= '0;
            click_time_b_reg       <= '0;
            last_gap_reg           <= '1;
            last_event_reg         <= EV_NONE;
        end else if (fire) begin
            press_captured_reg     <= press_captured_next;
            mark_time_reg          <= mark_time_next;
            long_reported_reg      <= long_reported_next;
            superlong_reported_reg <= superlong_reported_next;
            click_parity_reg       <= click_parity_next;
            click_time_a_reg       <= click_time_a_next;
            click_time_b_reg       <= click_time_b_next;
            last_gap_reg           <= last_gap_next;
            last_event_reg         <= last_event_next;
        end
    end

    // A long or super-long flag can only be set while a press is captured.
    assert property (@(posedge aclk) disable iff (!aresetn)
        long_reported_reg |-> press_captured_reg)
        else $error("long click flag set without a captured press");

    assert property (@(posedge aclk) disable iff (!aresetn)
        superlong_reported_reg |-> press_captured_reg)
        else $error("super-long flag set without a captured press");

    // The gap is only ever loaded from two differing click times.
    assert property (@(posedge aclk) disable iff (!aresetn)
        last_gap_reg != '0)
        else $error("click gap became zero");

    // Each reported click moves the next click time to the other slot.
    assert property (@(posedge aclk) disable iff (!aresetn)
        fire && click_hit |=> click_parity_reg != $past(click_parity_reg))
        else $error("click parity did not toggle on a click");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch click classifier testbench
// Drives touch samples through the valid/ready input channel and checks every
// result against an in-bench classifier or a directed row's own result. The
// directed table covers the reset behavior and the corner cases. Randomized
// press/release gestures and noise follow, under several register settings,
// with random idling on both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;
    import tcc_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int PHASE_ITEMS     = 240;
    localparam int NUM_PHASES      = 8;
    localparam int CALM_PHASE      = 5;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_LIMIT     = 2000;
    localparam int PRINT_LIMIT     = 40;
    localparam int NUM_ROWS        = 25;
    localparam int SPLIT_ROW       = 22;

    typedef struct packed {
        logic [15:0] level;
        logic [31:0] now;
        logic        has_want;
        result_t     want;
    } sample_row_t;

    // Rows with has_want set carry a result read straight off the spec; the
    // rest are checked against the classifier below. The rows from SPLIT_ROW on
    // run with a super-long delay shorter than the long delay.
    localparam sample_row_t DIRECTED_ROWS [NUM_ROWS] = '{
        '{16'hFFFF, 32'd0,     1'b1, '{EV_NONE,      EV_NONE,      1'b0, 1'b0}},
        '{16'h0000, 32'd10,    1'b1, '{EV_NONE,      EV_NONE,      1'b0, 1'b0}},
        '{16'h0000, 32'd1011,  1'b1, '{EV_LONG,      EV_LONG,      1'b1, 1'b0}},
        '{16'h0000, 32'd4012,  1'b1, '{EV_SUPERLONG, EV_SUPERLONG, 1'b0, 1'b0}},
        '{16'd29,   32'd9000,  1'b1, '{EV_NONE,      EV_SUPERLONG, 1'b0, 1'b0}},
        '{16'd30,   32'd9100,  1'b1, '{EV_NONE,      EV_SUPERLONG, 1'b0, 1'b0}},
        '{16'h0000, 32'd9200,  1'b1, '{EV_NONE,      EV_SUPERLONG, 1'b0, 1'b0}},
        '{16'hFFFF, 32'd9300,  1'b1, '{EV_CLICK,     EV_CLICK,     1'b0, 1'b1}},
        '{16'h0000, 32'd9310,  1'b1, '{EV_NONE,      EV_CLICK,     1'b0, 1'b0}},
        '{16'hFFFF, 32'd9400,  1'b1, '{EV_DOUBLE,    EV_DOUBLE,    1'b0, 1'b1}},
        '{16'hFFFF, 32'd9500,  1'b1, '{EV_DOUBLE,    EV_DOUBLE,    1'b0, 1'b1}},
        '{16'hFFFF, 32'd9900,  1'b1, '{EV_CLICK,     EV_CLICK,     1'b0, 1'b1}},
        '{16'hFFFF, 32'd9950,  1'b1, '{EV_NONE,      EV_CLICK,     1'b0, 1'b0}},
        '{16'h5555, 32'hFFFF_FFF0, 1'b0, '0},
        '{16'h0000, 32'hFFFF_FFF8, 1'b0, '0},
        '{16'h0001, 32'h0000_03F1, 1'b0, '0},
        '{16'hFFFF, 32'd20000, 1'b0, '0},
        '{16'hFFFF, 32'd20100, 1'b0, '0},
        '{16'h0000, 32'd5000,  1'b0, '0},
        '{16'hFFFF, 32'd20100, 1'b0, '0},
        '{16'hAAAA, 32'd20200, 1'b0, '0},
        '{16'h8000, 32'h7FFF_FFFF, 1'b0, '0},
        '{16'h0000, 32'h8000_0000, 1'b0, '0},
        '{16'h0000, 32'h8000_0096, 1'b1, '{EV_SUPERLONG, EV_SUPERLONG, 1'b0, 1'b0}},
        '{16'h0000, 32'h8000_0258, 1'b1, '{EV_LONG,      EV_LONG,      1'b1, 1'b0}}
    };

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       cfg_we = 1'b0;
    reg_index_t cfg_index = REG_TOUCH_THRESHOLD;
    cfg_word_t  cfg_wdata = '0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [15:0] s_touch_level = '0;
    logic [31:0] s_now_ms = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    event_t     m_event_code;
    event_t     m_held_state;
    logic       m_go_home_pulse;
    logic       m_stop_continue_pulse;

    // Side band that travels with each sample transfer.
    logic       row_has_want = 1'b0;
    result_t    row_want = '0;

    logic       hold_off_go = 1'b0;
    bit         calm = 1'b0;
    int         cycle_count = 0;
    int         mismatch_count = 0;
    int         items_sent = 0;
    logic [31:0] clock_ms;
    result_t    expected_results [$];

    // Classifier state and register shadow.
    cfg_t        cfg_shadow = '{RST_TOUCH_THRESHOLD, RST_CLICK_MIN, RST_LONG_PRESS,
                                RST_SUPERLONG_EXTRA, RST_DOUBLE_WINDOW};
    logic        pressing = 1'b0;
    logic [31:0] hold_mark = '0;
    logic        long_sent = 1'b0;
    logic        superlong_sent = 1'b0;
    logic        click_slot = 1'b0;
    logic [31:0] click_at_a = '0;
    logic [31:0] click_at_b = '0;
    logic [31:0] click_gap = '1;
    event_t      shown_event = EV_NONE;

    touch_click_classifier #(.TIME_WIDTH(32)) DUT (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_we              (cfg_we),
        .cfg_index           (cfg_index),
        .cfg_wdata           (cfg_wdata),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_touch_level       (s_touch_level),
        .s_now_ms            (s_now_ms),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_event_code        (m_event_code),
        .m_held_state        (m_held_state),
        .m_go_home_pulse     (m_go_home_pulse),
        .m_stop_continue_pulse(m_stop_continue_pulse)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic result_t classify_sample(input logic [15:0] level,
                                                input logic [31:0] now);
        result_t     r;
        logic [31:0] elapsed;
        r = '{EV_NONE, EV_NONE, 1'b0, 1'b0};
        if (level < cfg_shadow.touch_threshold) begin
            if (!pressing) begin
                hold_mark = now;
                pressing = 1'b1;
            end
            elapsed = now - hold_mark;
            if (elapsed > cfg_shadow.long_press_ms && !long_sent) begin
                hold_mark = now;
                long_sent = 1'b1;
                r.event_code = EV_LONG;
                r.go_home_pulse = 1'b1;
            end
            // The super-long test is separate, so it can fire before a long click.
            elapsed = now - hold_mark;
            if (elapsed > cfg_shadow.superlong_extra_ms && !superlong_sent) begin
                hold_mark = now;
                superlong_sent = 1'b1;
                r.event_code = EV_SUPERLONG;
            end
        end else begin
            elapsed = now - hold_mark;
            if (elapsed > cfg_shadow.click_min_ms && !long_sent) begin
                r.event_code = EV_CLICK;
                r.stop_continue_pulse = 1'b1;
                pressing = 1'b0;
                if (click_slot) begin
                    click_at_a = now;
                end else begin
                    click_at_b = now;
                end
                click_slot = !click_slot;
                if (click_at_a > click_at_b) begin
                    click_gap = click_at_a - click_at_b;
                end else if (click_at_a < click_at_b) begin
                    click_gap = click_at_b - click_at_a;
                end
                if (click_gap < cfg_shadow.double_window_ms) begin
                    r.event_code = EV_DOUBLE;
                end
            end
            long_sent = 1'b0;
            superlong_sent = 1'b0;
            hold_mark = now;
        end
        if (r.event_code != EV_NONE) begin
            shown_event = r.event_code;
        end
        r.held_state = shown_event;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_LIMIT) begin
            $display("%0t ns: mismatch: %s", $time, msg);
        end
        mismatch_count++;
    endtask

    always @(posedge aclk) begin
        result_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result transfer with nothing expected");
                end else begin
                    want = expected_results.pop_front();
                    if (m_event_code !== want.event_code) begin
                        report_mismatch($sformatf("event_code got %0d expected %0d",
                                                  m_event_code, want.event_code));
                    end
                    if (m_held_state !== want.held_state) begin
                        report_mismatch($sformatf("held_state got %0d expected %0d",
                                                  m_held_state, want.held_state));
                    end
                    if (m_go_home_pulse !== want.go_home_pulse) begin
                        report_mismatch($sformatf("go_home_pulse got %0b expected %0b",
                                                  m_go_home_pulse, want.go_home_pulse));
                    end
                    if (m_stop_continue_pulse !== want.stop_continue_pulse) begin
                        report_mismatch($sformatf("stop_continue_pulse got %0b expected %0b",
                                                  m_stop_continue_pulse,
                                                  want.stop_continue_pulse));
                    end
                end
            end
            if (s_valid && s_ready) begin
                want = classify_sample(s_touch_level, s_now_ms);
                if (row_has_want) begin
                    want = row_want;
                end
                expected_results.push_back(want);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Result side: random back-pressure, plus one long hold-off on request.
    initial begin : result_sink
        int held;
        bit hold_used;
        hold_used = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_go && !hold_used) begin
                hold_used = 1'b1;
                m_ready <= 1'b0;
                held = 0;
                while (held < HOLD_OFF_CYCLES) begin
                    @(posedge aclk);
                    held++;
                end
            end
            m_ready <= calm || ($urandom_range(0, 99) >= 37);
        end
    end

    // Leaves valid high across back-to-back transfers so it is never lowered
    // and raised in the same step.
    task automatic send_sample(input logic [15:0] level, input logic [31:0] now,
                               input logic has_want, input result_t want);
        int gap;
        gap = 0;
        if (!calm) begin
            while ($urandom_range(0, 99) < 37) gap++;
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_touch_level <= level;
        s_now_ms <= now;
        row_has_want <= has_want;
        row_want <= want;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_config(input cfg_t c);
        cfg_we <= 1'b1;
        cfg_index <= REG_TOUCH_THRESHOLD;
        cfg_wdata <= c.touch_threshold;
        @(posedge aclk);
        cfg_index <= REG_CLICK_MIN;
        cfg_wdata <= c.click_min_ms;
        @(posedge aclk);
        cfg_index <= REG_LONG_PRESS;
        cfg_wdata <= c.long_press_ms;
        @(posedge aclk);
        cfg_index <= REG_SUPERLONG_EXTRA;
        cfg_wdata <= c.superlong_extra_ms;
        @(posedge aclk);
        cfg_index <= REG_DOUBLE_WINDOW;
        cfg_wdata <= c.double_window_ms;
        @(posedge aclk);
        cfg_we <= 1'b0;
        cfg_shadow = c;
    endtask

    function automatic cfg_t phase_config(input int phase);
        cfg_t c;
        case (phase)
            0: c = '{RST_TOUCH_THRESHOLD, RST_CLICK_MIN, RST_LONG_PRESS,
                     RST_SUPERLONG_EXTRA, RST_DOUBLE_WINDOW};
            1: c = '{16'hFFFF, 16'd0, 16'd0, 16'd0, 16'hFFFF};
            2: c = '{16'($urandom_range(1, 65535)), 16'($urandom_range(0, 2000)),
                     16'($urandom_range(0, 2000)), 16'($urandom_range(0, 2000)),
                     16'($urandom_range(0, 2000))};
            3: c = '{16'd32768, 16'd20, 16'd400, 16'd100, 16'd300};
            4: c = '{16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0};
            5: c = '{16'($urandom_range(1, 65535)), 16'($urandom_range(0, 200)),
                     16'($urandom_range(0, 600)), 16'($urandom_range(0, 900)),
                     16'($urandom_range(0, 500))};
            6: c = '{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom)};
            default: c = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        endcase
        return c;
    endfunction

    function automatic logic [15:0] pick_level(input bit pressed);
        int unsigned thr;
        thr = 32'(cfg_shadow.touch_threshold);
        if (pressed && thr > 0) begin
            return ($urandom_range(0, 7) == 0) ? 16'(thr - 1) : 16'($urandom_range(0, thr - 1));
        end
        if (!pressed) begin
            return ($urandom_range(0, 7) == 0) ? 16'(thr) : 16'($urandom_range(thr, 65535));
        end
        // With a zero threshold nothing counts as touched.
        return 16'($urandom);
    endfunction

    // Steps scale with one of the timing registers so every delay is crossed.
    function automatic logic [31:0] pick_step();
        int unsigned base;
        case ($urandom_range(0, 3))
            0: base = 32'(cfg_shadow.click_min_ms);
            1: base = 32'(cfg_shadow.long_press_ms);
            2: base = 32'(cfg_shadow.superlong_extra_ms);
            default: base = 32'(cfg_shadow.double_window_ms);
        endcase
        return $urandom_range(0, base + 20);
    endfunction

    task automatic play_gesture();
        int n_press;
        int n_release;
        int k;
        n_press = $urandom_range(0, 8);
        n_release = $urandom_range(1, 3);
        for (k = 0; k < n_press; k++) begin
            send_sample(pick_level(1'b1), clock_ms, 1'b0, '0);
            clock_ms = clock_ms + pick_step();
        end
        for (k = 0; k < n_release; k++) begin
            send_sample(pick_level(1'b0), clock_ms, 1'b0, '0);
            clock_ms = clock_ms + pick_step();
        end
        // Short pauses between gestures bring clicks inside the double window.
        if ($urandom_range(0, 2) == 0) begin
            clock_ms = clock_ms + $urandom_range(0, cfg_shadow.double_window_ms + 10);
        end
    endtask

    task automatic play_noise();
        int n;
        int k;
        logic [31:0] stamp;
        n = $urandom_range(1, 3);
        for (k = 0; k < n; k++) begin
            stamp = $urandom;
            send_sample(16'($urandom), stamp, 1'b0, '0);
            if ($urandom_range(0, 1) == 0) begin
                clock_ms = stamp;
            end
        end
    endtask

    initial begin : stimulus
        int row;
        int phase;
        int start;
        int pick;
        int waited;
        clock_ms = $urandom;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (row = 0; row < NUM_ROWS; row++) begin
            if (row == SPLIT_ROW) begin
                settle();
                write_config('{RST_TOUCH_THRESHOLD, RST_CLICK_MIN, 16'd400, 16'd100,
                               RST_DOUBLE_WINDOW});
            end
            send_sample(DIRECTED_ROWS[row].level, DIRECTED_ROWS[row].now,
                        DIRECTED_ROWS[row].has_want, DIRECTED_ROWS[row].want);
        end
        settle();

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            write_config(phase_config(phase));
            if (phase == CALM_PHASE) begin
                // No idling here; the receiver also holds off once so the
                // block fills up while samples keep coming.
                calm = 1'b1;
                hold_off_go <= 1'b1;
            end
            start = items_sent;
            while (items_sent - start < PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 15) begin
                    play_noise();
                end else begin
                    if (pick < 20) begin
                        clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 5000);
                    end
                    play_gesture();
                end
            end
            settle();
            calm = 1'b0;
        end

        waited = 0;
        while (expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (8) @(posedge aclk);
        if (expected_results.size() != 0) begin
            report_mismatch($sformatf("%0d expected results never arrived",
                                      expected_results.size()));
        end
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/tcc_pkg.sv
sv/tcc_core.sv
sv/touch_click_classifier.sv
test/tb.sv
